@@ rtl/brs_pkg.sv @@
// Package for the block request scoreboard.
// Holds payload structs, controller/datapath command and status types, codes and defaults.
// No dependencies.
package brs_pkg;

    // Default sizing
    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_BLOCK_BYTES = 16384;

    // Configuration port geometry (total_length needs a 64-bit data path)
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;
    localparam int TL_W   = 48;

    // Register indexes
    localparam logic [1:0] REG_BLOCK_COUNT   = 2'd0;
    localparam logic [1:0] REG_LAST_PIECE    = 2'd1;
    localparam logic [1:0] REG_TOTAL_LENGTH  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd3;

    // Register reset values
    localparam logic [6:0]  RST_BLOCK_COUNT   = 7'd64;
    localparam logic [31:0] RST_TIMEOUT_TICKS = 32'd7000;

    // Item modes
    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_FILL    = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;
    localparam logic [1:0] MODE_RESET   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_NONE_FREE = 2'd1;
    localparam logic [1:0] ERR_RETRIEVED = 2'd2;
    localparam logic [1:0] ERR_NO_OFFSET = 2'd3;

    // Per-block state codes
    localparam logic [1:0] BLK_MISSING   = 2'd0;
    localparam logic [1:0] BLK_PENDING   = 2'd1;
    localparam logic [1:0] BLK_RETRIEVED = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [19:0] fill_offset;
    } t_item;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [19:0] request_offset;
        logic [14:0] request_length;
        logic        piece_full;
        logic        can_request;
    } t_result;

    // Controller state
    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SCAN
    } t_fsm_e;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;
        logic scan_run;
        logic clr_run;
        logic emit;
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic scan_done;
        logic clr_done;
    } t_dp_sts;

endpackage

@@ rtl/brs_cfg.sv @@
// Configuration registers of the block request scoreboard with APB-style access.
// Also reduces total_length modulo the block size, one 16-bit digit at a time (quotient step, then remainder step).
// Depends on brs_pkg.
module brs_cfg #(
    parameter int MAX_BLOCKS  = brs_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = brs_pkg::DEF_BLOCK_BYTES,
    localparam int CW = $clog2(MAX_BLOCKS + 1),
    localparam int RW = $clog2(BLOCK_BYTES + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brs_pkg::APB_AW-1:0] paddr,
    input  logic [brs_pkg::APB_DW-1:0] pwdata,
    output logic [brs_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output logic [CW-1:0]              o_n_use,
    output logic                       o_last_piece,
    output logic [RW-1:0]              o_rem,
    output logic [31:0]                o_timeout,
    output logic                       o_busy
);
    import brs_pkg::*;

    localparam int DIG_W = 16;
    localparam int N_DIG = TL_W / DIG_W;
    localparam int CNT_W = $clog2(2 * N_DIG + 1);
    localparam int SH    = $clog2(BLOCK_BYTES);
    localparam int QW    = 17;
    // Scaled reciprocal of the block size: exact floor division of any 32-bit value
    localparam logic [33:0] RECIP =
        34'(((64'd1 << (32 + SH)) / 64'(BLOCK_BYTES)) + 64'd1);

    logic [6:0]       r_block_count;
    logic             r_last_piece;
    logic [TL_W-1:0]  r_total_length;
    logic [31:0]      r_timeout;
    logic [TL_W-1:0]  r_shift;
    logic [RW-1:0]    r_rem;
    logic [QW-1:0]    r_quo;
    logic [CNT_W-1:0] r_rem_cnt;

    logic             wr_en;
    logic [1:0]       reg_idx;
    logic [31:0]      rem_v;
    logic [65:0]      rem_prod;
    logic [31:0]      rem_back;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:3];

    // Digit step: v = rem * 2^16 + digit, quotient by reciprocal, then remainder
    assign rem_v    = {DIG_W'(r_rem), r_shift[TL_W-1 -: DIG_W]};
    assign rem_prod = {34'd0, rem_v} * {32'd0, RECIP};
    assign rem_back = rem_v - 32'(r_quo) * 32'(BLOCK_BYTES);

    // Register writes and remainder sequence (even count: quotient, odd: remainder)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count  <= RST_BLOCK_COUNT;
            r_last_piece   <= 1'b0;
            r_total_length <= '0;
            r_timeout      <= RST_TIMEOUT_TICKS;
            r_rem          <= '0;
            r_quo          <= '0;
            r_rem_cnt      <= '0;
            r_shift        <= '0;
        end else begin
            if (r_rem_cnt != '0) begin
                if (!r_rem_cnt[0]) begin
                    r_quo <= rem_prod[32 + SH +: QW];
                end else begin
                    r_rem   <= rem_back[RW-1:0];
                    r_shift <= {r_shift[TL_W-DIG_W-1:0], {DIG_W{1'b0}}};
                end
                r_rem_cnt <= r_rem_cnt - CNT_W'(1);
            end
            if (wr_en) begin
                unique case (reg_idx)
                    REG_BLOCK_COUNT:   r_block_count <= pwdata[6:0];
                    REG_LAST_PIECE:    r_last_piece  <= pwdata[0];
                    REG_TOTAL_LENGTH: begin
                        r_total_length <= pwdata[TL_W-1:0];
                        r_shift        <= pwdata[TL_W-1:0];
                        r_rem          <= '0;
                        r_rem_cnt      <= CNT_W'(2 * N_DIG);
                    end
                    REG_TIMEOUT_TICKS: r_timeout     <= pwdata[31:0];
                    default: ;
                endcase
            end
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_BLOCK_COUNT:   prdata = APB_DW'(r_block_count);
            REG_LAST_PIECE:    prdata = APB_DW'(r_last_piece);
            REG_TOTAL_LENGTH:  prdata = APB_DW'(r_total_length);
            REG_TIMEOUT_TICKS: prdata = APB_DW'(r_timeout);
            default:           prdata = '0;
        endcase
    end

    // Blocks in use: count saturated to the table depth
    assign o_n_use      = (32'(r_block_count) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS)
                                                                  : CW'(r_block_count);
    assign o_last_piece = r_last_piece;
    assign o_rem        = r_rem;
    assign o_timeout    = r_timeout;
    assign o_busy       = (r_rem_cnt != '0);

endmodule

@@ rtl/brs_ctrl.sv @@
// Controller of the block request scoreboard: sequences clear sweeps and table scans.
// Drives the datapath through t_dp_cmd and watches t_dp_sts.
// Depends on brs_pkg.
module brs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [1:0]       i_mode,
    input  brs_pkg::t_dp_sts i_sts,
    output brs_pkg::t_dp_cmd o_cmd,
    output logic             o_busy
);
    import brs_pkg::*;

    t_fsm_e r_state;
    t_fsm_e n_state;

    // State register; reset starts with a clear sweep of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_mode == MODE_RESET) ? ST_CLEAR : ST_SCAN;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_run = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

@@ rtl/brs_dp.sv @@
// Datapath of the block request scoreboard: block state and stamp memories, tick
// counter, sequential scan with target selection, write-back and result register.
// Depends on brs_pkg.
module brs_dp #(
    parameter int MAX_BLOCKS  = brs_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = brs_pkg::DEF_BLOCK_BYTES,
    localparam int CW = $clog2(MAX_BLOCKS + 1),
    localparam int RW = $clog2(BLOCK_BYTES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  brs_pkg::t_dp_cmd i_cmd,
    output brs_pkg::t_dp_sts o_sts,
    input  brs_pkg::t_item   i_item,
    input  logic [CW-1:0]    i_n_use,
    input  logic             i_last_piece,
    input  logic [RW-1:0]    i_rem,
    input  logic [31:0]      i_timeout,
    output logic             o_done,
    output brs_pkg::t_result o_result
);
    import brs_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int OW = $clog2(MAX_BLOCKS * BLOCK_BYTES + 1);

    // Table memories
    logic [1:0]  mem_st [MAX_BLOCKS];
    logic [31:0] mem_sp [MAX_BLOCKS];

    logic [1:0]    r_mode;
    logic [19:0]   r_foff;
    logic [31:0]   r_time;
    logic [CW-1:0] r_rd_idx;
    logic          r_dv;
    logic [CW-1:0] r_di;
    logic [OW-1:0] r_doff;
    logic [1:0]    r_st_q;
    logic [31:0]   r_sp_q;
    logic          r_found;
    logic [IW-1:0] r_tidx;
    logic [OW-1:0] r_toff;
    logic          r_tlast;
    logic          r_tret;
    logic          r_full;
    logic          r_avail;
    logic [IW-1:0] r_clr_idx;
    logic          r_done;
    t_result       r_result;

    logic          issue;
    logic          ready;
    logic          is_ret;
    logic          is_target;
    logic          clr_last;
    logic          wr_pending;
    logic          wr_retrieved;
    logic [31:0]   elapsed;
    logic [31:0]   len32;
    logic [31:0]   off32;
    t_result       res;

    // Per-entry evaluation of the registered read data
    assign elapsed = r_time - r_sp_q;
    assign is_ret  = (r_st_q == BLK_RETRIEVED);
    assign ready   = (r_st_q == BLK_MISSING) ||
                     ((r_st_q == BLK_PENDING) && (elapsed > i_timeout));

    always_comb begin
        case (r_mode)
            MODE_REQUEST: is_target = ready && !r_found;
            MODE_FILL:    is_target = !r_found && (32'(r_doff) == 32'(r_foff));
            default:      is_target = 1'b0;
        endcase
    end

    assign issue    = i_cmd.scan_run && (r_rd_idx < i_n_use);
    assign clr_last = (r_clr_idx == IW'(MAX_BLOCKS - 1));

    // Scan pipeline, tick counter and clear index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time    <= '0;
            r_rd_idx  <= '0;
            r_dv      <= 1'b0;
            r_di      <= '0;
            r_doff    <= '0;
            r_found   <= 1'b0;
            r_tret    <= 1'b0;
            r_tlast   <= 1'b0;
            r_full    <= 1'b1;
            r_avail   <= 1'b0;
            r_clr_idx <= '0;
            r_mode    <= MODE_TICK;
        end else begin
            if (i_cmd.load) begin
                r_mode   <= i_item.mode;
                r_rd_idx <= '0;
                r_dv     <= 1'b0;
                r_di     <= '0;
                r_doff   <= '0;
                r_found  <= 1'b0;
                r_tret   <= 1'b0;
                r_tlast  <= 1'b0;
                r_full   <= 1'b1;
                r_avail  <= 1'b0;
                if (i_item.mode == MODE_TICK) r_time <= r_time + 32'd1;
            end else begin
                r_dv <= issue;
                if (issue) r_rd_idx <= r_rd_idx + CW'(1);
                if (r_dv) begin
                    r_di   <= r_di + CW'(1);
                    r_doff <= r_doff + OW'(BLOCK_BYTES);
                    if (is_target) begin
                        r_found <= 1'b1;
                        r_tret  <= is_ret;
                        r_tlast <= (CW'(r_di + CW'(1)) == i_n_use);
                    end
                    // Flags reflect the table after this item's write-back
                    if (!(is_target && r_mode == MODE_FILL)) begin
                        if (!is_ret) r_full <= 1'b0;
                    end
                    if (ready && !is_target) r_avail <= 1'b1;
                end
            end
            if (i_cmd.clr_run) r_clr_idx <= clr_last ? '0 : r_clr_idx + IW'(1);
        end
    end

    // Target fields carry no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_foff <= i_item.fill_offset;
        if (r_dv && is_target) begin
            r_tidx <= r_di[IW-1:0];
            r_toff <= r_doff;
        end
    end

    // Registered memory reads
    always_ff @(posedge i_clk) begin
        r_st_q <= mem_st[r_rd_idx[IW-1:0]];
        r_sp_q <= mem_sp[r_rd_idx[IW-1:0]];
    end

    // Write-back at result time, or clear sweep
    assign wr_pending   = i_cmd.emit && (r_mode == MODE_REQUEST) && r_found;
    assign wr_retrieved = i_cmd.emit && (r_mode == MODE_FILL) && r_found && !r_tret;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_run) begin
            mem_st[r_clr_idx] <= BLK_MISSING;
        end else if (wr_pending) begin
            mem_st[r_tidx] <= BLK_PENDING;
        end else if (wr_retrieved) begin
            mem_st[r_tidx] <= BLK_RETRIEVED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_pending) mem_sp[r_tidx] <= r_time;
    end

    // Result assembly
    assign len32 = (i_last_piece && r_tlast && (i_rem != '0)) ? 32'(i_rem)
                                                             : 32'(BLOCK_BYTES);
    assign off32 = 32'(r_toff);

    always_comb begin
        res             = '0;
        res.error_code  = ERR_OK;
        res.piece_full  = r_full;
        res.can_request = r_avail;
        case (r_mode)
            MODE_REQUEST: begin
                if (r_found) begin
                    res.request_offset = off32[19:0];
                    res.request_length = len32[14:0];
                end else begin
                    res.error_code = ERR_NONE_FREE;
                end
            end
            MODE_FILL: begin
                if (!r_found)    res.error_code = ERR_NO_OFFSET;
                else if (r_tret) res.error_code = ERR_RETRIEVED;
            end
            MODE_RESET: begin
                res.piece_full  = (i_n_use == '0);
                res.can_request = (i_n_use != '0);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_result <= res;
    end

    assign o_sts.scan_done = (r_rd_idx == i_n_use) && !r_dv;
    assign o_sts.clr_done  = clr_last;
    assign o_done          = r_done;
    assign o_result        = r_result;

endmodule

@@ rtl/block_request_scoreboard.sv @@
// Top level of the block request scoreboard.
// Instantiates brs_cfg, brs_ctrl and brs_dp; depends on brs_pkg.
//
// Usage:
//  - Command channel: an item (mode, fill_offset) is taken at a clock edge where
//    start is high and busy is low.
//  - Result channel: o_done is high for one cycle with o_result; there is no
//    backpressure, the receiver must take it in that cycle.
//  - Configuration: APB-style port, 64-bit data, register i at byte 8*i
//    (block_count, last_piece, total_length, timeout_ticks); pready is always high.
//  - Scanning: request, fill and tick items scan the n blocks in use through one
//    memory read port, one entry per cycle; busy drops as o_done rises, so a new
//    item is taken only once the previous result is out.
//  - A reset item clears the whole state memory, one entry per cycle, before its result.
//  - A write of total_length reduces it modulo the block size one 16-bit digit
//    at a time (quotient step, then remainder step); busy stays high until done.
//  - After reset, busy is high during a clearing pass of the whole state
//    memory; configuration writes are taken throughout.
module block_request_scoreboard #(
    parameter int MAX_BLOCKS  = brs_pkg::DEF_MAX_BLOCKS,
    parameter int BLOCK_BYTES = brs_pkg::DEF_BLOCK_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  brs_pkg::t_item             i_cmd,
    output logic                       o_done,
    output brs_pkg::t_result           o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [brs_pkg::APB_AW-1:0] paddr,
    input  logic [brs_pkg::APB_DW-1:0] pwdata,
    output logic [brs_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import brs_pkg::*;

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int RW = $clog2(BLOCK_BYTES + 1);

    logic          accept;
    logic          ctrl_busy;
    logic          cfg_busy;
    logic [CW-1:0] n_use;
    logic          last_piece;
    logic [RW-1:0] rem;
    logic [31:0]   timeout;
    t_dp_cmd       dp_cmd;
    t_dp_sts       dp_sts;

    // Item handshake
    assign busy   = ctrl_busy || cfg_busy;
    assign accept = start && !busy;

    brs_cfg #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_n_use      (n_use),
        .o_last_piece (last_piece),
        .o_rem        (rem),
        .o_timeout    (timeout),
        .o_busy       (cfg_busy)
    );

    brs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_cmd.mode),
        .i_sts    (dp_sts),
        .o_cmd    (dp_cmd),
        .o_busy   (ctrl_busy)
    );

    brs_dp #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_item       (i_cmd),
        .i_n_use      (n_use),
        .i_last_piece (last_piece),
        .i_rem        (rem),
        .i_timeout    (timeout),
        .o_done       (o_done),
        .o_result     (o_result)
    );

endmodule
